// ----- sv/scc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// types and constants shared by the component labelling core
// ----------------------------------------------------------------------------
package scc_pkg;
  localparam int unsigned VERTICES_DEFAULT = 16;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_P1_ROOT,
    ST_P1_TOP,
    ST_P1_SCAN,
    ST_P2_ROOT,
    ST_P2_POP,
    ST_P2_SCAN,
    ST_EMIT,
    ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

// ----- sv/strongly_connected_components_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strongly_connected_components_core
// two-pass depth-first component labelling over an adjacency matrix
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    row_index, row_adjacency, last_row (tlast)
// m_axis   out  tvalid/tready    vertex_id, component_id, component_count,
//                                last_result (tlast)
// a plain row only stores its adjacency; a last row also starts both searches
// one edge test per cycle in the scan states of both searches,
// then V results, one per cycle when the sink is ready, then a clear sweep of all rows
// s_axis_tready is low from the last row until the clear sweep ends
// rst is synchronous and returns the core to row loading with empty rows
module strongly_connected_components_core #(
  parameter int unsigned VERTICES = scc_pkg::VERTICES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // [3:0] row_index, [19:4] row_adjacency, [23:20] zero
  input  wire logic [scc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic s_axis_tlast,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // [3:0] vertex_id, [7:4] component_id, [12:8] component_count, [15:13] zero
  output logic [scc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic      m_axis_tlast
);
  localparam int unsigned VW = $clog2(VERTICES);
  localparam int unsigned CW = $clog2(VERTICES + 1);
  localparam logic [VW-1:0] VMAX = VW'(VERTICES - 1);

  scc_pkg::state_t state, state_next;

  logic [VERTICES-1:0] adj [VERTICES];
  logic [VERTICES-1:0] visited;
  logic [VW-1:0]       finish [VERTICES];
  logic [CW-1:0]       finish_count;
  logic [VW-1:0]       stack [VERTICES];
  logic [CW-1:0]       depth;
  logic [VW-1:0]       labels [VERTICES];
  logic [CW-1:0]       comps;
  logic [CW-1:0]       cursor [VERTICES];
  logic [CW-1:0]       root;
  logic [VW-1:0]       cur;
  logic [CW-1:0]       scan;
  logic [VW-1:0]       idx;

  logic       in_fire, out_fire;
  logic [3:0] in_row;
  logic [VW-1:0] j;
  logic [VW-1:0] u;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign in_row   = s_axis_tdata[3:0];
  assign s_axis_tready = (state == scc_pkg::ST_LOAD);
  assign m_axis_tvalid = (state == scc_pkg::ST_EMIT);
  assign m_axis_tlast  = (state == scc_pkg::ST_EMIT) && (idx == VMAX);
  assign m_axis_tdata  = {3'b000, 5'(comps), 4'(labels[idx]), 4'(idx)};

  assign j = VW'(cursor[cur] - 1'b1);
  assign u = VW'(scan - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      scc_pkg::ST_LOAD:    if (in_fire && s_axis_tlast) state_next = scc_pkg::ST_P1_ROOT;
      scc_pkg::ST_P1_ROOT: if (root == CW'(VERTICES)) state_next = scc_pkg::ST_P2_ROOT;
                           else if (!visited[root[VW-1:0]]) state_next = scc_pkg::ST_P1_TOP;
      scc_pkg::ST_P1_TOP:  state_next = scc_pkg::ST_P1_SCAN;
      scc_pkg::ST_P1_SCAN: begin
        if (cursor[cur] == '0 || (adj[cur][j] && !visited[j])) begin
          if (cursor[cur] == '0 && depth == CW'(1)) state_next = scc_pkg::ST_P1_ROOT;
          else state_next = scc_pkg::ST_P1_TOP;
        end
      end
      scc_pkg::ST_P2_ROOT: if (root == '0) state_next = scc_pkg::ST_EMIT;
                           else if (!visited[finish[VW'(root - 1'b1)]])
                             state_next = scc_pkg::ST_P2_POP;
      scc_pkg::ST_P2_POP:  if (depth == '0) state_next = scc_pkg::ST_P2_ROOT;
                           else state_next = scc_pkg::ST_P2_SCAN;
      scc_pkg::ST_P2_SCAN: if (scan == CW'(1)) state_next = scc_pkg::ST_P2_POP;
      scc_pkg::ST_EMIT:    if (out_fire && idx == VMAX) state_next = scc_pkg::ST_CLEAR;
      scc_pkg::ST_CLEAR:   if (idx == VMAX) state_next = scc_pkg::ST_LOAD;
      default:             state_next = scc_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VERTICES; k++) adj[k] <= '0;
      visited <= '0;
      finish_count <= '0;
      comps <= '0;
      depth <= '0;
      root <= '0;
      idx <= '0;
    end else begin
      case (state)
        scc_pkg::ST_LOAD: begin
          if (in_fire) begin
            if (32'(in_row) < VERTICES)
              adj[VW'(in_row)] <= VERTICES'(s_axis_tdata[19:4]);
            if (s_axis_tlast) begin
              visited <= '0;
              finish_count <= '0;
              root <= '0;
            end
          end
        end
        scc_pkg::ST_P1_ROOT: begin
          if (root == CW'(VERTICES)) begin
            visited <= '0;
            comps <= '0;
            root <= finish_count;
          end else begin
            if (!visited[root[VW-1:0]]) begin
              visited[root[VW-1:0]] <= 1'b1;
              stack[0] <= root[VW-1:0];
              cursor[root[VW-1:0]] <= CW'(VERTICES);
              depth <= CW'(1);
            end
            root <= root + 1'b1;
          end
        end
        scc_pkg::ST_P1_TOP: cur <= stack[VW'(depth - 1'b1)];
        scc_pkg::ST_P1_SCAN: begin
          if (cursor[cur] == '0) begin
            depth <= depth - 1'b1;
            finish[VW'(finish_count)] <= cur;
            finish_count <= finish_count + 1'b1;
          end else begin
            cursor[cur] <= cursor[cur] - 1'b1;
            if (adj[cur][j] && !visited[j]) begin
              visited[j] <= 1'b1;
              cursor[j] <= CW'(VERTICES);
              stack[VW'(depth)] <= j;
              depth <= depth + 1'b1;
            end
          end
        end
        scc_pkg::ST_P2_ROOT: begin
          if (root != '0) begin
            if (!visited[finish[VW'(root - 1'b1)]]) begin
              visited[finish[VW'(root - 1'b1)]] <= 1'b1;
              labels[finish[VW'(root - 1'b1)]] <= VW'(comps);
              comps <= comps + 1'b1;
              stack[0] <= finish[VW'(root - 1'b1)];
              depth <= CW'(1);
            end
            root <= root - 1'b1;
          end else begin
            idx <= '0;
          end
        end
        scc_pkg::ST_P2_POP: begin
          if (depth != '0) begin
            cur <= stack[VW'(depth - 1'b1)];
            depth <= depth - 1'b1;
            scan <= CW'(VERTICES);
          end
        end
        scc_pkg::ST_P2_SCAN: begin
          if (adj[u][cur] && !visited[u]) begin
            visited[u] <= 1'b1;
            labels[u] <= VW'(comps - 1'b1);
            stack[VW'(depth)] <= u;
            depth <= depth + 1'b1;
          end
          scan <= scan - 1'b1;
        end
        scc_pkg::ST_EMIT: begin
          if (out_fire) idx <= (idx == VMAX) ? '0 : idx + 1'b1;
        end
        scc_pkg::ST_CLEAR: begin
          adj[idx] <= '0;
          idx <= (idx == VMAX) ? '0 : idx + 1'b1;
          if (idx == VMAX) begin
            visited <= '0;
            finish_count <= '0;
            comps <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("load and emit overlap");
  a_last_ends_emit: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast) |=> (state == scc_pkg::ST_CLEAR))
    else $error("emit did not end on last");
  a_comps_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (comps != '0)) else $error("no components at emit");
  a_finish_full: assert property (@(posedge clk) disable iff (rst)
    (state == scc_pkg::ST_P2_ROOT && $past(state) == scc_pkg::ST_P1_ROOT)
    |-> (root == CW'(VERTICES))) else $error("finish order incomplete");
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks strongly connected component labelling: graphs are streamed in as
// adjacency rows, an internal kosaraju predictor forms the expected labels,
// and every output transfer is compared against them in order
// ----------------------------------------------------------------------------
module tb_top;
  localparam int unsigned V = 16;

  typedef struct packed {
    logic [3:0] vertex;
    logic [3:0] comp;
    logic [4:0] count;
    logic       last;
  } label_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [scc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [scc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  logic [V-1:0] graph_rows [V];
  label_t       label_queue [$];
  int           errors = 0;
  int           graphs = 0;
  int           rows_sent = 0;
  int           labels_seen = 0;
  bit           sink_steady = 1'b0;
  bit           src_steady = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  strongly_connected_components_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // kosaraju over the stored rows, appends one label per vertex
  task automatic predict_components();
    bit       seen [V];
    int       order [V];
    int       order_n;
    int       stack [V];
    int       cursor [V];
    int       depth;
    int       top;
    int       lbl [V];
    int       found;
    int       root;
    bit       pushed;
    label_t   r;
    order_n = 0;
    foreach (seen[i]) seen[i] = 0;
    for (int s = 0; s < V; s++) begin
      if (!seen[s]) begin
        seen[s] = 1; stack[0] = s; cursor[s] = V; depth = 1;
        while (depth > 0) begin
          top = stack[depth-1];
          pushed = 0;
          while (cursor[top] > 0 && !pushed) begin
            cursor[top]--;
            if (graph_rows[top][cursor[top]] && !seen[cursor[top]]) begin
              seen[cursor[top]] = 1;
              cursor[cursor[top]] = V;
              stack[depth++] = cursor[top];
              pushed = 1;
            end
          end
          if (!pushed) begin
            depth--;
            order[order_n++] = top;
          end
        end
      end
    end
    foreach (seen[i]) seen[i] = 0;
    found = 0;
    for (int k = order_n; k > 0; k--) begin
      root = order[k-1];
      if (!seen[root]) begin
        seen[root] = 1; lbl[root] = found; stack[0] = root; depth = 1;
        while (depth > 0) begin
          top = stack[--depth];
          for (int u = V - 1; u >= 0; u--) begin
            if (graph_rows[u][top] && !seen[u]) begin
              seen[u] = 1; lbl[u] = found;
              stack[depth++] = u;
            end
          end
        end
        found++;
      end
    end
    for (int w = 0; w < V; w++) begin
      r.vertex = w[3:0];
      r.comp   = lbl[w][3:0];
      r.count  = found[4:0];
      r.last   = (w == V - 1);
      label_queue.push_back(r);
    end
    foreach (graph_rows[i]) graph_rows[i] = '0;
    graphs++;
  endtask

  // tvalid stays high after a plain row; the next call either idles it or
  // replaces the data, so it is written once per clock edge
  task automatic send_row(input logic [3:0] idx, input logic [15:0] adj, input bit fin);
    while (!src_steady && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, adj, idx};
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    rows_sent++;
    graph_rows[idx] = adj;
    if (fin) begin
      predict_components();
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (label_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_graph();
    send_row(4'd0, 16'h0000, 1'b1);
  endtask

  task automatic test_full_graph();
    for (int i = 0; i < V; i++) send_row(i[3:0], 16'hffff, i == V - 1);
  endtask

  task automatic test_ring_and_chain();
    // a ring whose row 3 is then emptied, then a descending chain with a rewritten row
    for (int i = 0; i < V; i++) send_row(i[3:0], 16'h1 << ((i + 1) % V), 1'b0);
    send_row(4'd3, 16'h0000, 1'b1);
    for (int i = 1; i < V; i++) send_row(i[3:0], 16'h1 << (i - 1), 1'b0);
    send_row(4'd5, 16'h0020, 1'b1);
  endtask

  task automatic test_random_graphs();
    int n;
    logic [15:0] adj;
    while (rows_sent < 230) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(2))
          0: adj = 16'($urandom & $urandom);
          1: adj = 16'h1 << $urandom_range(15);
          default: adj = 16'($urandom);
        endcase
        send_row(4'($urandom_range(15)), adj, i == n - 1);
      end
      if (graphs == 8) begin
        wait_drained();
        src_steady = 1'b1;
        sink_steady = 1'b1;
      end
      if (graphs == 12) begin
        src_steady = 1'b0;
        sink_steady = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_steady || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    label_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      labels_seen++;
      if (label_queue.size() == 0) begin
        $error("unexpected transfer tdata=%h", m_axis_tdata);
        errors++;
      end else begin
        want = label_queue.pop_front();
        if (m_axis_tdata[3:0] !== want.vertex) begin
          $error("vertex_id expected %0d actual %0d", want.vertex, m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tdata[7:4] !== want.comp) begin
          $error("component_id expected %0d actual %0d", want.comp, m_axis_tdata[7:4]);
          errors++;
        end
        if (m_axis_tdata[12:8] !== want.count) begin
          $error("component_count expected %0d actual %0d", want.count,
                 m_axis_tdata[12:8]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_result expected %0d actual %0d", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_graph();
    test_full_graph();
    test_ring_and_chain();
    test_random_graphs();
    wait_drained();
    repeat (100) @(posedge clk);
    $display("run covered %0d rows in %0d graphs, %0d labels checked",
             rows_sent, graphs, labels_seen);
    if (errors == 0 && label_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
